[sv/ffba_pkg.sv]
// Shared constants, command codes and controller states of the first-fit block allocator.
`default_nettype none

package ffba_pkg;

	localparam int ARENA_SIZE_DEF  = 4096;
	localparam int HEADER_SIZE_DEF = 16;

	localparam int CMD_W = 2;
	localparam int REQ_W = 13;
	localparam int OFF_W = 12;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC  = 2'd0,
		CMD_FREE   = 2'd1,
		CMD_REINIT = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALLOC,
		ST_SPLIT,
		ST_FREE_HDR,
		ST_FREE_NEXT,
		ST_RESP
	} state_t;

endpackage

`default_nettype wire

[sv/first_fit_block_allocator_unit.sv]
// First-fit block allocator over a header memory with one read and one write port.
// The arena is a chain of blocks, each led by a header (free flag, payload size) kept in a
// synchronous memory indexed by byte offset; the header at offset zero lives in a register so
// that reset makes the whole arena one free block without a clearing pass. Commands are taken
// one at a time, and the next transaction is accepted while a finished result still waits in
// the output register. An allocate reads one header per cycle while it walks the chain, and
// a split writes the second header in a further step; a free reads the freed header and,
// when another header follows inside the arena, that next header before it writes back;
// a reinitialize writes only header zero. The walk over the memory read port is what sets
// the allocate time, so heavy fragmentation makes allocation slower.
`default_nettype none

module first_fit_block_allocator_unit #(
	parameter int ARENA_SIZE  = ffba_pkg::ARENA_SIZE_DEF,
	parameter int HEADER_SIZE = ffba_pkg::HEADER_SIZE_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [ffba_pkg::CMD_W-1:0] command,
	input  logic [ffba_pkg::REQ_W-1:0] request_size,
	input  logic [ffba_pkg::OFF_W-1:0] block_offset,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       status,
	output logic [ffba_pkg::OFF_W-1:0] payload_offset
);
	import ffba_pkg::*;

	localparam int AW = $clog2(ARENA_SIZE);
	localparam int SW = $clog2(ARENA_SIZE + 1);
	localparam int CW = (AW + 2 > REQ_W + 1) ? AW + 2 : REQ_W + 1;
	localparam logic [CW-1:0] HC = CW'(HEADER_SIZE);
	localparam logic [CW-1:0] AC = CW'(ARENA_SIZE);
	localparam logic [SW-1:0] WHOLE_SIZE = SW'(ARENA_SIZE - HEADER_SIZE);

	logic [SW:0] mem [ARENA_SIZE];
	logic [SW:0] hdr0_q;
	logic [SW:0] rd_data_s1;
	logic [AW-1:0] rd_addr_s1;

	state_t state_q, state_d;

	logic [CW-1:0] req_q, off_q, cur_q, cur_d;
	logic [AW-1:0] h_q;
	logic [SW-1:0] szh_q;
	logic [AW-1:0] split_addr_q, split_addr_d;
	logic [SW:0] split_data_q, split_data_d;
	logic res_status_q, res_status_d;
	logic [OFF_W-1:0] res_off_q, res_off_d;
	logic out_valid_q, status_q;
	logic [OFF_W-1:0] payload_offset_q;

	logic in_acc, res_ld, split_ld, szh_ld, out_ld;
	logic rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [SW:0] wr_data;

	logic [SW:0] hdr_rd;
	logic hdr_free;
	logic [SW-1:0] hdr_sz;
	logic [CW-1:0] hsz, hend, left, nxtp, nsum, nsat, off_ext, hoff;
	logic fit, split;

	assign in_acc = in_valid && !in_stall;

	assign hdr_rd = (rd_addr_s1 == '0) ? hdr0_q : rd_data_s1;
	assign hdr_free = hdr_rd[SW];
	assign hdr_sz = hdr_rd[SW-1:0];
	assign hsz = CW'(hdr_sz);
	assign hend = cur_q + HC + hsz;
	assign fit = hdr_free && (hsz >= req_q);
	assign left = hsz - req_q;
	assign split = left >= HC;
	assign nxtp = off_q + hsz;
	assign nsum = CW'(szh_q) + hsz + HC;
	assign nsat = (nsum > AC) ? AC : nsum;
	assign off_ext = CW'(block_offset);
	assign hoff = off_ext - HC;

	always_comb begin
		state_d = state_q;
		in_stall = 1'b1;
		cur_d = cur_q;
		rd_en = 1'b0;
		rd_addr = '0;
		wr_en = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		res_ld = 1'b0;
		res_status_d = 1'b0;
		res_off_d = '0;
		split_ld = 1'b0;
		split_addr_d = '0;
		split_data_d = '0;
		szh_ld = 1'b0;
		out_ld = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					case (command)
						CMD_ALLOC: begin
							cur_d = '0;
							rd_en = 1'b1;
							rd_addr = '0;
							state_d = ST_ALLOC;
						end
						CMD_FREE: begin
							if (off_ext < HC || hoff >= AC) begin
								state_d = ST_RESP;
							end else begin
								rd_en = 1'b1;
								rd_addr = hoff[AW-1:0];
								state_d = ST_FREE_HDR;
							end
						end
						CMD_REINIT: begin
							wr_en = 1'b1;
							wr_addr = '0;
							wr_data = {1'b1, WHOLE_SIZE};
							state_d = ST_RESP;
						end
						default: begin
							state_d = ST_RESP;
						end
					endcase
				end
			end
			ST_ALLOC: begin
				if (hend > AC) begin
					res_ld = 1'b1;
					res_status_d = 1'b1;
					state_d = ST_RESP;
				end else if (fit) begin
					wr_en = 1'b1;
					wr_addr = cur_q[AW-1:0];
					wr_data = {1'b0, split ? SW'(req_q) : hdr_sz};
					res_ld = 1'b1;
					res_off_d = OFF_W'(cur_q + HC);
					if (split) begin
						split_ld = 1'b1;
						split_addr_d = AW'(cur_q + HC + req_q);
						split_data_d = {1'b1, SW'(left - HC)};
						state_d = ST_SPLIT;
					end else begin
						state_d = ST_RESP;
					end
				end else if (hend + HC > AC) begin
					res_ld = 1'b1;
					res_status_d = 1'b1;
					state_d = ST_RESP;
				end else begin
					cur_d = hend;
					rd_en = 1'b1;
					rd_addr = hend[AW-1:0];
				end
			end
			ST_SPLIT: begin
				wr_en = 1'b1;
				wr_addr = split_addr_q;
				wr_data = split_data_q;
				state_d = ST_RESP;
			end
			ST_FREE_HDR: begin
				szh_ld = 1'b1;
				if (nxtp + HC <= AC) begin
					rd_en = 1'b1;
					rd_addr = nxtp[AW-1:0];
					state_d = ST_FREE_NEXT;
				end else begin
					wr_en = 1'b1;
					wr_addr = h_q;
					wr_data = {1'b1, hdr_sz};
					state_d = ST_RESP;
				end
			end
			ST_FREE_NEXT: begin
				wr_en = 1'b1;
				wr_addr = h_q;
				wr_data = {1'b1, hdr_free ? SW'(nsat) : szh_q};
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (!out_valid_q || !out_stall) begin
					out_ld = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr0_q <= {1'b1, WHOLE_SIZE};
		end else if (wr_en && wr_addr == '0) begin
			hdr0_q <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && wr_addr != '0) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			rd_addr_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		if (in_acc) begin
			req_q <= CW'(request_size);
			off_q <= off_ext;
			h_q <= hoff[AW-1:0];
		end
		if (split_ld) begin
			split_addr_q <= split_addr_d;
			split_data_q <= split_data_d;
		end
		if (szh_ld) begin
			szh_q <= hdr_sz;
		end
		if (in_acc) begin
			res_status_q <= 1'b0;
			res_off_q <= '0;
		end else if (res_ld) begin
			res_status_q <= res_status_d;
			res_off_q <= res_off_d;
		end
		if (out_ld) begin
			status_q <= res_status_q;
			payload_offset_q <= res_off_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign payload_offset = payload_offset_q;

endmodule

`default_nettype wire

[sv/ffba_checker.sv]
// Port-level checks of the first-fit block allocator and their binding to the top level.
`default_nettype none

module ffba_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_stall,
	input wire logic                       out_valid,
	input wire logic                       out_stall,
	input wire logic                       status,
	input wire logic [ffba_pkg::OFF_W-1:0] payload_offset
);

	// The block works on one transaction at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while a transaction is in progress");

	// A failed allocation never carries an offset.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> payload_offset == '0)
		else $error("failed result with nonzero payload offset");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(status) && $stable(payload_offset))
		else $error("stalled result changed");

endmodule

bind first_fit_block_allocator_unit ffba_checker u_ffba_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.status         (status),
	.payload_offset (payload_offset)
);

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the first-fit block allocator: random and directed commands with a header-walk predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ffba_pkg::*;

	localparam int ARENA = ARENA_SIZE_DEF;
	localparam int HDR = HEADER_SIZE_DEF;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef enum int {OFF_GIVEN, OFF_LIVE, OFF_ANY_HEADER} off_pick_t;

	typedef struct {
		logic [CMD_W-1:0] cmd;
		logic [REQ_W-1:0] req;
		logic [OFF_W-1:0] off;
		off_pick_t        pick;
	} alloc_cmd_t;

	typedef struct {
		logic             status;
		logic [OFF_W-1:0] payload_offset;
	} alloc_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [CMD_W-1:0] command = CMD_ALLOC;
	logic [REQ_W-1:0] request_size = '0;
	logic [OFF_W-1:0] block_offset = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic             status;
	logic [OFF_W-1:0] payload_offset;

	bit            hdr_is_free [ARENA];
	int            hdr_len [ARENA];
	bit            hdr_known [ARENA];
	int            known_headers [$];
	int            live_blocks [$];
	alloc_cmd_t    queued_cmds [$];
	alloc_result_t results_due [$];
	alloc_cmd_t    next_cmd;
	alloc_result_t want;

	bit in_taken = 1'b0;
	int pushed_cnt = 0;
	int accepted_cnt = 0;
	int results_seen = 0;
	int mismatches = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;

	first_fit_block_allocator_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.request_size(request_size),
		.block_offset(block_offset),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.payload_offset(payload_offset)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void note_header(int at, bit fr, int len);
		hdr_is_free[at] = fr;
		hdr_len[at] = len;
		if (!hdr_known[at]) begin
			hdr_known[at] = 1'b1;
			known_headers.push_back(at);
		end
	endfunction

	// Header walk from offset zero, split or whole-block hand-out, free with forward merge.
	function automatic alloc_result_t apply_command(logic [CMD_W-1:0] cmd, logic [REQ_W-1:0] req,
			logic [OFF_W-1:0] off);
		alloc_result_t r;
		int cur;
		int len;
		int stop;
		int h;
		int nxt;
		int sum;
		int i;
		bit done;
		r.status = 1'b0;
		r.payload_offset = '0;
		case (cmd)
			CMD_ALLOC: begin
				r.status = 1'b1;
				cur = 0;
				done = 1'b0;
				while (!done && cur + HDR <= ARENA) begin
					len = hdr_len[cur];
					stop = cur + HDR + len;
					if (stop > ARENA) begin
						done = 1'b1;
					end else if (hdr_is_free[cur] && len >= int'(req)) begin
						hdr_is_free[cur] = 1'b0;
						if (len - int'(req) >= HDR) begin
							hdr_len[cur] = int'(req);
							note_header(cur + HDR + int'(req), 1'b1, len - int'(req) - HDR);
						end
						r.status = 1'b0;
						r.payload_offset = OFF_W'(cur + HDR);
						if (cur + HDR < ARENA)
							live_blocks.push_back(cur + HDR);
						done = 1'b1;
					end else begin
						cur = stop;
					end
				end
			end
			CMD_FREE: begin
				h = int'(off) - HDR;
				if (int'(off) >= HDR && h < ARENA) begin
					hdr_is_free[h] = 1'b1;
					nxt = int'(off) + hdr_len[h];
					if (nxt + HDR <= ARENA && hdr_is_free[nxt]) begin
						sum = hdr_len[h] + hdr_len[nxt] + HDR;
						hdr_len[h] = (sum > ARENA) ? ARENA : sum;
					end
					done = 1'b0;
					for (i = 0; i < live_blocks.size() && !done; i++) begin
						if (live_blocks[i] == int'(off)) begin
							live_blocks.delete(i);
							done = 1'b1;
						end
					end
				end
			end
			CMD_REINIT: begin
				note_header(0, 1'b1, ARENA - HDR);
				live_blocks.delete();
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 50)
			$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	task automatic add_item(logic [CMD_W-1:0] cmd, int req, int off, off_pick_t pick);
		alloc_cmd_t c;
		c.cmd = cmd;
		c.req = REQ_W'(req);
		c.off = OFF_W'(off);
		c.pick = pick;
		queued_cmds.push_back(c);
		pushed_cnt++;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (accepted_cnt != pushed_cnt || results_due.size() != 0);
	endtask

	task automatic run_phase(int idle_in, int stall_in, int hold, int n);
		int i;
		int r;
		int s;
		int req;
		@(posedge clk);
		send_idle_pct = idle_in;
		stall_pct = stall_in;
		hold_left = hold;
		for (i = 0; i < n; i++) begin
			r = $urandom_range(99);
			s = $urandom_range(99);
			if (s < 70)
				req = $urandom_range(64);
			else if (s < 90)
				req = $urandom_range(512, 65);
			else if (s < 98)
				req = $urandom_range(4096, 513);
			else
				req = s[0] ? 4096 : 0;
			if (r < 48)
				add_item(CMD_ALLOC, req, $urandom_range(4095), OFF_GIVEN);
			else if (r < 83)
				add_item(CMD_FREE, $urandom_range(4096), 0, OFF_LIVE);
			else if (r < 88)
				add_item(CMD_FREE, $urandom_range(4096), 0, OFF_ANY_HEADER);
			else if (r < 91)
				add_item(CMD_FREE, $urandom_range(4096), $urandom_range(HDR - 1), OFF_GIVEN);
			else if (r < 93)
				add_item(CMD_REINIT, $urandom_range(4096), $urandom_range(4095), OFF_GIVEN);
			else if (r < 94)
				add_item(CMD_UNUSED, $urandom_range(4096), $urandom_range(4095), OFF_GIVEN);
			else
				add_item(CMD_ALLOC, $urandom_range(HDR), $urandom_range(4095), OFF_GIVEN);
		end
		wait_drained();
	endtask

	// Free offsets are chosen when the transaction is loaded, so they follow the current arena.
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			in_taken = 1'b0;
			if (queued_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_cmd = queued_cmds.pop_front();
				if (next_cmd.pick == OFF_LIVE && live_blocks.size() != 0)
					next_cmd.off = OFF_W'(live_blocks[$urandom_range(live_blocks.size() - 1)]);
				else if (next_cmd.pick != OFF_GIVEN)
					next_cmd.off = OFF_W'(known_headers[$urandom_range(known_headers.size() - 1)] + HDR);
				in_valid <= 1'b1;
				command <= next_cmd.cmd;
				request_size <= next_cmd.req;
				block_offset <= next_cmd.off;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (results_due.size() == 0) begin
					report_mismatch($sformatf("result %0d with no transaction pending", results_seen));
				end else begin
					want = results_due.pop_front();
					if (status !== want.status)
						report_mismatch($sformatf("result %0d status %0b, expected %0b",
							results_seen, status, want.status));
					if (payload_offset !== want.payload_offset)
						report_mismatch($sformatf("result %0d payload_offset %0d, expected %0d",
							results_seen, payload_offset, want.payload_offset));
				end
			end
			if (in_valid && !in_stall && !in_taken) begin
				results_due.push_back(apply_command(command, request_size, block_offset));
				accepted_cnt++;
				in_taken = 1'b1;
			end
		end
	end

	initial begin
		note_header(0, 1'b1, ARENA - HDR);
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_item(CMD_ALLOC, 4096, 4095, OFF_GIVEN);
		add_item(CMD_ALLOC, 0, 0, OFF_GIVEN);
		add_item(CMD_FREE, 4096, 0, OFF_GIVEN);
		add_item(CMD_FREE, 0, HDR - 1, OFF_GIVEN);
		add_item(CMD_UNUSED, 4096, 4095, OFF_GIVEN);
		add_item(CMD_FREE, 0, HDR, OFF_GIVEN);
		add_item(CMD_ALLOC, ARENA - HDR, 0, OFF_GIVEN);
		add_item(CMD_ALLOC, 1, 4095, OFF_GIVEN);
		add_item(CMD_REINIT, 4096, 4095, OFF_GIVEN);
		// The split leaves a zero-size block at the arena end, whose payload offset wraps to zero.
		add_item(CMD_ALLOC, ARENA - 2 * HDR, 0, OFF_GIVEN);
		add_item(CMD_ALLOC, 0, 0, OFF_GIVEN);
		add_item(CMD_ALLOC, ARENA - 2 * HDR + 1, 0, OFF_GIVEN);
		add_item(CMD_FREE, 0, HDR, OFF_GIVEN);
		add_item(CMD_ALLOC, ARENA - 2 * HDR - 14, 0, OFF_GIVEN);
		add_item(CMD_REINIT, 0, 0, OFF_GIVEN);
		add_item(CMD_ALLOC, 100, 0, OFF_GIVEN);
		add_item(CMD_ALLOC, 200, 0, OFF_GIVEN);
		add_item(CMD_ALLOC, ARENA - 300 - 3 * HDR, 0, OFF_GIVEN);
		add_item(CMD_FREE, 0, HDR, OFF_GIVEN);
		add_item(CMD_FREE, 0, 2 * HDR + 100, OFF_GIVEN);
		add_item(CMD_FREE, 0, HDR, OFF_GIVEN);
		add_item(CMD_ALLOC, 300 + HDR, 0, OFF_GIVEN);
		add_item(CMD_FREE, 0, 3 * HDR + 300, OFF_GIVEN);
		add_item(CMD_ALLOC, 3000, 0, OFF_GIVEN);
		wait_drained();

		run_phase(0, 0, 0, 360);
		run_phase(66, 0, 0, 360);
		run_phase(0, 66, 0, 360);
		run_phase(23, 23, 0, 360);
		run_phase(0, 0, 400, 360);

		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#30_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

[filelist.f]
sv/ffba_pkg.sv
sv/first_fit_block_allocator_unit.sv
sv/ffba_checker.sv
tb/testbench.sv
